FILE: hdl/range_flow_table_switch_defines.svh
// Assertion macros shared by the range flow table switch RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef RANGE_FLOW_TABLE_SWITCH_DEFINES_SVH
`define RANGE_FLOW_TABLE_SWITCH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge out of reset.
`define RFTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfts assertion failed");
// Next-cycle implication, checked on every rising edge out of reset.
`define RFTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfts assertion failed");
`else
`define RFTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define RFTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/rfts_pkg.sv
// Types, sizes and codes shared by the range flow table switch.
// Depends on nothing; the RTL files refer to it by scoped names and the bench imports it.
package rfts_pkg;

	localparam int RULE_DEPTH = 16;
	localparam int ADDR_BITS = 10;
	localparam int IDX_W = $clog2(RULE_DEPTH);
	localparam int CNT_W = $clog2(RULE_DEPTH + 1);
	localparam int PORT_W = 3;
	localparam int NB_W = PORT_W + 1;
	localparam int COUNT_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int OUT_NUM_W = 5;

	localparam logic [PORT_W-1:0] LOCAL_PORT = PORT_W'(3);
	localparam logic [ADDR_BITS-1:0] MAX_SRC_RESET = ADDR_BITS'(1000);
	localparam logic [NB_W-1:0] NB_NONE = '1;

	typedef enum logic [1:0] {
		CMD_ADMIT       = 2'd0,
		CMD_ADD         = 2'd1,
		CMD_RELAY       = 2'd2,
		CMD_HELLO_REPLY = 2'd3
	} cmd_t;

	localparam logic [1:0] RELAY_NONE = 2'd0;
	localparam logic [1:0] RELAY_A = 2'd1;
	localparam logic [1:0] RELAY_B = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOUR_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SRC = 3'd4;

	typedef struct packed {
		cmd_t cmd;
		logic [ADDR_BITS-1:0] src_addr;
		logic [ADDR_BITS-1:0] dst_addr;
		logic rule_drop;
		logic [PORT_W-1:0] rule_port;
		logic [ADDR_BITS-1:0] rule_dst_low;
		logic [ADDR_BITS-1:0] rule_dst_high;
	} in_word_t;

	typedef struct packed {
		logic ask;
		logic [ADDR_BITS-1:0] ask_src;
		logic [ADDR_BITS-1:0] ask_dst;
		logic [1:0] relay_to;
		logic [OUT_NUM_W-1:0] hits;
		logic inserted;
		logic table_full;
		logic [OUT_NUM_W-1:0] rules_in_use;
	} out_word_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] dst_low;
		logic [ADDR_BITS-1:0] dst_high;
		logic drop;
		logic [PORT_W-1:0] port;
		logic [COUNT_W-1:0] count;
	} rule_t;

	// One bump request per event counter but the hello-sent count, raised for a single cycle.
	typedef struct packed {
		logic admit;
		logic hello_reply;
		logic add;
		logic relay_in;
		logic ask;
		logic relay_out;
	} evt_bump_t;

endpackage

FILE: hdl/rfts_if.sv
// Handshake channels of the range flow table switch: input, result, configuration.
// Depends on rfts_pkg for the payload types and widths.
interface rfts_in_if;
	logic valid;
	logic ready;
	rfts_pkg::in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rfts_out_if;
	logic valid;
	logic ready;
	rfts_pkg::out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface rfts_cfg_if;
	logic valid;
	logic ready;
	logic [rfts_pkg::CFG_IDX_W-1:0] index;
	logic [rfts_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/rfts_rule_mem.sv
// Rule memory: one write port, one read port with registered read data.
// Depends on rfts_pkg for the rule entry type and depth.
module rfts_rule_mem (
	input  logic clk,
	input  logic we,
	input  logic [rfts_pkg::IDX_W-1:0] waddr,
	input  rfts_pkg::rule_t wdata,
	input  logic re,
	input  logic [rfts_pkg::IDX_W-1:0] raddr,
	output rfts_pkg::rule_t rdata
);

	rfts_pkg::rule_t mem_q [rfts_pkg::RULE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/rfts_rule_cmp.sv
// Shared rule compare unit: range match for a packet, exact range match for an add.
// Depends on rfts_pkg for address widths.
module rfts_rule_cmp (
	input  logic is_add,
	input  logic [rfts_pkg::ADDR_BITS-1:0] rule_low,
	input  logic [rfts_pkg::ADDR_BITS-1:0] rule_high,
	input  logic [rfts_pkg::ADDR_BITS-1:0] max_src,
	input  logic [rfts_pkg::ADDR_BITS-1:0] src,
	input  logic [rfts_pkg::ADDR_BITS-1:0] dst,
	input  logic [rfts_pkg::ADDR_BITS-1:0] add_low,
	input  logic [rfts_pkg::ADDR_BITS-1:0] add_high,
	output logic hit
);

	logic pkt_hit;
	logic add_hit;

	// A packet hits when its source is within bounds and its destination is in range.
	assign pkt_hit = (src <= max_src) && (rule_low <= dst) && (dst <= rule_high);
	assign add_hit = (rule_low == add_low) && (rule_high == add_high);
	assign hit = is_add ? add_hit : pkt_hit;

endmodule

FILE: hdl/rfts_evt_cnt.sv
// Event counters of the switch, each but the hello-sent count bumped by a one-cycle request.
// Depends on rfts_pkg for the request struct and counter width.
module rfts_evt_cnt (
	input  logic clk,
	input  logic arst_n,
	input  rfts_pkg::evt_bump_t bump
);

	logic [rfts_pkg::COUNT_W-1:0] admit_q;
	logic [rfts_pkg::COUNT_W-1:0] hello_reply_q;
	logic [rfts_pkg::COUNT_W-1:0] add_q;
	logic [rfts_pkg::COUNT_W-1:0] relay_in_q;
	logic [rfts_pkg::COUNT_W-1:0] hello_sent_q;
	logic [rfts_pkg::COUNT_W-1:0] ask_q;
	logic [rfts_pkg::COUNT_W-1:0] relay_out_q;

	// The hello sent at power-up is counted by the reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admit_q <= '0;
			hello_reply_q <= '0;
			add_q <= '0;
			relay_in_q <= '0;
			hello_sent_q <= rfts_pkg::COUNT_W'(1);
			ask_q <= '0;
			relay_out_q <= '0;
		end else begin
			if (bump.admit) admit_q <= admit_q + 1'b1;
			if (bump.hello_reply) hello_reply_q <= hello_reply_q + 1'b1;
			if (bump.add) add_q <= add_q + 1'b1;
			if (bump.relay_in) relay_in_q <= relay_in_q + 1'b1;
			if (bump.ask) ask_q <= ask_q + 1'b1;
			if (bump.relay_out) relay_out_q <= relay_out_q + 1'b1;
		end
	end

endmodule

FILE: hdl/range_flow_table_switch.sv
// Top level of the range flow table switch: sequencer, rule scan and result register.
// Depends on rfts_pkg, rfts_if, rfts_rule_mem, rfts_rule_cmp, rfts_evt_cnt and the defines.
//
//   Channel   Direction  Contents
//   in_ch     sink       cmd, addresses and add-rule fields of one command word
//   out_ch    source     ask, relay choice, hit count, insert and table status
//   cfg_ch    sink       register index and data for the five configuration registers
//
// An admit or add word is scanned against every rule held when it is accepted, one
// rule per cycle through the shared compare unit, set by the single read port of the
// rule memory; the read and compare stages then fill and drain, and the result is
// loaded. A relay or hello acknowledgement word goes straight to the result load.
// in_ch is ready again the cycle after the result is loaded. A result waiting on
// out_ch does not block acceptance, but the next result is held until the previous
// one is taken. Reset is asynchronous and leaves one rule, the local rule, in the
// table; there is no clearing pass.
`include "range_flow_table_switch_defines.svh"

module range_flow_table_switch (
	input  logic clk,
	input  logic arst_n,
	rfts_in_if.sink in_ch,
	rfts_out_if.source out_ch,
	rfts_cfg_if.sink cfg_ch
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [rfts_pkg::ADDR_BITS-1:0] local_low_q;
	logic [rfts_pkg::ADDR_BITS-1:0] local_high_q;
	logic [rfts_pkg::NB_W-1:0] nb_a_q;
	logic [rfts_pkg::NB_W-1:0] nb_b_q;
	logic [rfts_pkg::ADDR_BITS-1:0] max_src_q;

	// The accepted command word.
	rfts_pkg::in_word_t cur_q;

	// Scan control: issue counter and the compare stage fed by the memory read.
	logic [rfts_pkg::CNT_W-1:0] iss_q;
	logic cmp_vld_s1;
	logic [rfts_pkg::IDX_W-1:0] cmp_idx_s1;

	// Table bookkeeping and per-word results.
	logic [rfts_pkg::CNT_W-1:0] rule_total_q;
	logic [rfts_pkg::COUNT_W-1:0] rule0_cnt_q;
	logic [rfts_pkg::CNT_W-1:0] hits_q;
	logic ins_q;
	logic full_q;

	rfts_pkg::out_word_t out_q;
	logic out_vld_q;

	// Memory and compare wiring.
	rfts_pkg::rule_t rd_data;
	rfts_pkg::rule_t wdata;
	logic mem_we;
	logic [rfts_pkg::IDX_W-1:0] waddr;
	logic rd_en;
	logic [rfts_pkg::ADDR_BITS-1:0] cmp_low;
	logic [rfts_pkg::ADDR_BITS-1:0] cmp_high;
	logic cmp_hit;
	logic rule_hit;
	logic scan_end;
	logic need_ins;
	logic room;
	logic ins_we;
	logic in_acc;
	logic out_load;
	rfts_pkg::out_word_t res;
	rfts_pkg::evt_bump_t bump;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_vld_q;
	assign out_ch.data = out_q;

	// Rules are read one per cycle while the issue counter is below the rule total.
	assign rd_en = (state_q == ST_SCAN) && (iss_q < rule_total_q);

	// Rule 0 takes its range from the live configuration registers.
	assign cmp_low = (cmp_idx_s1 == '0) ? local_low_q : rd_data.dst_low;
	assign cmp_high = (cmp_idx_s1 == '0) ? local_high_q : rd_data.dst_high;

	rfts_rule_cmp u_cmp (
		.is_add(cur_q.cmd == rfts_pkg::CMD_ADD),
		.rule_low(cmp_low),
		.rule_high(cmp_high),
		.max_src(max_src_q),
		.src(cur_q.src_addr),
		.dst(cur_q.dst_addr),
		.add_low(cur_q.rule_dst_low),
		.add_high(cur_q.rule_dst_high),
		.hit(cmp_hit)
	);

	assign rule_hit = (state_q == ST_SCAN) && cmp_vld_s1 && cmp_hit;
	assign scan_end = (state_q == ST_SCAN) && (iss_q == rule_total_q) && !cmp_vld_s1;
	assign need_ins = scan_end && (cur_q.cmd == rfts_pkg::CMD_ADD) && (hits_q == '0);
	assign room = (rule_total_q < rfts_pkg::CNT_W'(rfts_pkg::RULE_DEPTH));
	assign ins_we = need_ins && room;

	// A hit on a stored rule writes back its count plus one; an insert writes a fresh
	// rule at the end of the table. The two never fall in the same cycle, because an
	// insert is decided only after the compare stage has drained.
	always_comb begin
		mem_we = 1'b0;
		waddr = cmp_idx_s1;
		wdata = rd_data;
		if (rule_hit && (cmp_idx_s1 != '0)) begin
			mem_we = 1'b1;
			wdata.count = rd_data.count + 1'b1;
		end else if (ins_we) begin
			mem_we = 1'b1;
			waddr = rule_total_q[rfts_pkg::IDX_W-1:0];
			wdata.dst_low = cur_q.rule_dst_low;
			wdata.dst_high = cur_q.rule_dst_high;
			wdata.drop = cur_q.rule_drop;
			wdata.port = cur_q.rule_port;
			wdata.count = rfts_pkg::COUNT_W'(1);
		end
	end

	rfts_rule_mem u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(waddr),
		.wdata(wdata),
		.re(rd_en),
		.raddr(iss_q[rfts_pkg::IDX_W-1:0]),
		.rdata(rd_data)
	);

	// Result of the current word, valid in the done state. A forward add relays to the
	// first neighbour whose switch number equals the rule port; a neighbour of -1 never
	// matches since the port is zero-extended.
	always_comb begin
		res = '0;
		res.hits = rfts_pkg::OUT_NUM_W'(hits_q);
		res.inserted = ins_q;
		res.table_full = full_q;
		res.rules_in_use = rfts_pkg::OUT_NUM_W'(rule_total_q);
		if ((cur_q.cmd == rfts_pkg::CMD_ADMIT) && (hits_q == '0)) begin
			res.ask = 1'b1;
			res.ask_src = cur_q.src_addr;
			res.ask_dst = cur_q.dst_addr;
		end
		if ((cur_q.cmd == rfts_pkg::CMD_ADD) && !cur_q.rule_drop) begin
			if (nb_a_q == {1'b0, cur_q.rule_port}) begin
				res.relay_to = rfts_pkg::RELAY_A;
			end else if (nb_b_q == {1'b0, cur_q.rule_port}) begin
				res.relay_to = rfts_pkg::RELAY_B;
			end else begin
				res.relay_to = rfts_pkg::RELAY_NONE;
			end
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_vld_q || out_ch.ready);

	// Event counters are bumped once per word, when its result is loaded.
	always_comb begin
		bump = '0;
		if (out_load) begin
			bump.admit = (cur_q.cmd == rfts_pkg::CMD_ADMIT);
			bump.hello_reply = (cur_q.cmd == rfts_pkg::CMD_HELLO_REPLY);
			bump.add = (cur_q.cmd == rfts_pkg::CMD_ADD);
			bump.relay_in = (cur_q.cmd == rfts_pkg::CMD_RELAY);
			bump.ask = res.ask;
			bump.relay_out = (cur_q.cmd == rfts_pkg::CMD_ADD) && !cur_q.rule_drop;
		end
	end

	rfts_evt_cnt u_evt (
		.clk(clk),
		.arst_n(arst_n),
		.bump(bump)
	);

	// Configuration writes; indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_low_q <= '0;
			local_high_q <= '0;
			nb_a_q <= rfts_pkg::NB_NONE;
			nb_b_q <= rfts_pkg::NB_NONE;
			max_src_q <= rfts_pkg::MAX_SRC_RESET;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				rfts_pkg::CFG_LOCAL_LOW: begin
					local_low_q <= cfg_ch.data[rfts_pkg::ADDR_BITS-1:0];
				end
				rfts_pkg::CFG_LOCAL_HIGH: begin
					local_high_q <= cfg_ch.data[rfts_pkg::ADDR_BITS-1:0];
				end
				rfts_pkg::CFG_NEIGHBOUR_A: begin
					nb_a_q <= cfg_ch.data[rfts_pkg::NB_W-1:0];
				end
				rfts_pkg::CFG_NEIGHBOUR_B: begin
					nb_b_q <= cfg_ch.data[rfts_pkg::NB_W-1:0];
				end
				rfts_pkg::CFG_MAX_SRC: begin
					max_src_q <= cfg_ch.data[rfts_pkg::ADDR_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Command word register; loaded on acceptance only.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_q <= in_ch.data;
		end
	end

	// Sequencer with the scan pipeline and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			rule_total_q <= rfts_pkg::CNT_W'(1);
			rule0_cnt_q <= '0;
			hits_q <= '0;
			ins_q <= 1'b0;
			full_q <= 1'b0;
			out_vld_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_vld_q && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						iss_q <= '0;
						cmp_vld_s1 <= 1'b0;
						hits_q <= '0;
						ins_q <= 1'b0;
						full_q <= 1'b0;
						if ((in_ch.data.cmd == rfts_pkg::CMD_ADMIT) ||
							(in_ch.data.cmd == rfts_pkg::CMD_ADD)) begin
							state_q <= ST_SCAN;
						end else begin
							// A relay arrival always lands on the local rule.
							if (in_ch.data.cmd == rfts_pkg::CMD_RELAY) begin
								rule0_cnt_q <= rule0_cnt_q + 1'b1;
								hits_q <= rfts_pkg::CNT_W'(1);
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= rd_en;
					cmp_idx_s1 <= iss_q[rfts_pkg::IDX_W-1:0];
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (rule_hit) begin
						hits_q <= hits_q + 1'b1;
						if (cmp_idx_s1 == '0) begin
							rule0_cnt_q <= rule0_cnt_q + 1'b1;
						end
					end
					if (scan_end) begin
						if (ins_we) begin
							rule_total_q <= rule_total_q + 1'b1;
							ins_q <= 1'b1;
						end else if (need_ins) begin
							full_q <= 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_q <= res;
						out_vld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The block is busy in the cycle after it takes a word.
	`RFTS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !in_ch.ready)
	// An insert grows the table by exactly one rule.
	`RFTS_ASSERT_NEXT(a_insert_grows, clk, arst_n, ins_we,
		rule_total_q == $past(rule_total_q) + 1'b1)
	// The compare stage only ever looks at rules held in the table.
	`RFTS_ASSERT_SAME(a_scan_in_table, clk, arst_n, cmp_vld_s1 && (state_q == ST_SCAN),
		{1'b0, cmp_idx_s1} < rule_total_q)
	// An ask is raised only by a packet that hit no rule.
	`RFTS_ASSERT_SAME(a_ask_no_hits, clk, arst_n, out_vld_q && out_q.ask,
		(out_q.hits == '0) && !out_q.inserted)

endmodule

FILE: verif/tb.sv
// Self-checking bench for the range flow table switch: rule match, add, relay and ask words.
// Depends on rfts_pkg, the rfts_*_if channel interfaces and the range_flow_table_switch RTL.
`timescale 1ns / 100ps

module tb;
	import rfts_pkg::*;

	// Receiver back-pressure styles, chosen per phase by the stimulus sequence.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PATTERN
	} stall_style_t;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 300000;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Everything the bench drives into the block starts at a known value at time zero.
	logic in_valid = 1'b0;
	in_word_t in_word = '0;
	logic out_ready = 1'b0;
	logic cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rfts_in_if cmd_bus();
	rfts_out_if res_bus();
	rfts_cfg_if reg_bus();

	assign cmd_bus.valid = in_valid;
	assign cmd_bus.data = in_word;
	assign res_bus.ready = out_ready;
	assign reg_bus.valid = cfg_valid;
	assign reg_bus.index = cfg_index;
	assign reg_bus.data = cfg_data;

	range_flow_table_switch u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(cmd_bus),
		.out_ch(res_bus),
		.cfg_ch(reg_bus)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Command words waiting to be offered, and the results the table still owes us.
	in_word_t cmd_backlog[$];
	out_word_t owed_results[$];

	// Shadow copy of the configuration registers, updated on each register write.
	logic [ADDR_BITS-1:0] reg_local_low;
	logic [ADDR_BITS-1:0] reg_local_high;
	logic [ADDR_BITS-1:0] reg_max_src;
	logic [NB_W-1:0] reg_nb_a;
	logic [NB_W-1:0] reg_nb_b;

	// Shadow copy of the rule table. Entry 0 takes its range from the local registers,
	// so only its hit count is kept here.
	logic [ADDR_BITS-1:0] tbl_low [RULE_DEPTH];
	logic [ADDR_BITS-1:0] tbl_high [RULE_DEPTH];
	logic tbl_drop [RULE_DEPTH];
	logic [PORT_W-1:0] tbl_port [RULE_DEPTH];
	logic [COUNT_W-1:0] tbl_hits [RULE_DEPTH];
	int tbl_used;

	// Knobs that the stimulus sequence turns between phases.
	logic sender_gaps;
	stall_style_t stall_mode;
	int hold_requests;

	int fault_count = 0;
	int unsigned cycle_count = 0;

	// Applies one accepted command word to the shadow table and returns the result
	// word the block must produce for it.
	function automatic out_word_t table_predict(in_word_t w);
		out_word_t r;
		logic [ADDR_BITS-1:0] lo;
		logic [ADDR_BITS-1:0] hi;
		int n;
		int matched;
		int i;
		r = '0;
		n = tbl_used;
		matched = 0;
		case (w.cmd)
			CMD_ADMIT: begin
				for (i = 0; i < n; i++) begin
					lo = (i == 0) ? reg_local_low : tbl_low[i];
					hi = (i == 0) ? reg_local_high : tbl_high[i];
					// The source bound is shared by every rule and read live.
					if (w.src_addr <= reg_max_src && lo <= w.dst_addr && w.dst_addr <= hi) begin
						tbl_hits[i] = tbl_hits[i] + 1'b1;
						matched++;
					end
				end
				// A packet that no rule holds raises exactly one ask.
				if (matched == 0) begin
					r.ask = 1'b1;
					r.ask_src = w.src_addr;
					r.ask_dst = w.dst_addr;
				end
			end
			CMD_ADD: begin
				for (i = 0; i < n; i++) begin
					lo = (i == 0) ? reg_local_low : tbl_low[i];
					hi = (i == 0) ? reg_local_high : tbl_high[i];
					if (lo == w.rule_dst_low && hi == w.rule_dst_high) begin
						tbl_hits[i] = tbl_hits[i] + 1'b1;
						matched++;
					end
				end
				if (matched == 0) begin
					if (n < RULE_DEPTH) begin
						tbl_low[n] = w.rule_dst_low;
						tbl_high[n] = w.rule_dst_high;
						tbl_drop[n] = w.rule_drop;
						tbl_port[n] = w.rule_port;
						tbl_hits[n] = 1;
						n++;
						r.inserted = 1'b1;
					end else begin
						r.table_full = 1'b1;
					end
				end
				// A negative neighbour number never equals a port, so only the
				// non-negative codes can select a relay; neighbour a wins a tie.
				if (!w.rule_drop) begin
					if (!reg_nb_a[NB_W-1] && reg_nb_a[PORT_W-1:0] == w.rule_port)
						r.relay_to = RELAY_A;
					else if (!reg_nb_b[NB_W-1] && reg_nb_b[PORT_W-1:0] == w.rule_port)
						r.relay_to = RELAY_B;
				end
			end
			CMD_RELAY: begin
				tbl_hits[0] = tbl_hits[0] + 1'b1;
				matched = 1;
			end
			default: begin
			end
		endcase
		tbl_used = n;
		r.hits = OUT_NUM_W'(matched);
		r.rules_in_use = OUT_NUM_W'(n);
		return r;
	endfunction

	function automatic string result_text(out_word_t r);
		return $sformatf("ask=%0d src=%0d dst=%0d relay=%0d hits=%0d ins=%0d full=%0d rules=%0d",
			r.ask, r.ask_src, r.ask_dst, r.relay_to, r.hits, r.inserted, r.table_full,
			r.rules_in_use);
	endfunction

	function automatic in_word_t word_of(cmd_t c, logic [ADDR_BITS-1:0] src,
			logic [ADDR_BITS-1:0] dst, logic drop, logic [PORT_W-1:0] port,
			logic [ADDR_BITS-1:0] lo, logic [ADDR_BITS-1:0] hi);
		in_word_t w;
		w.cmd = c;
		w.src_addr = src;
		w.dst_addr = dst;
		w.rule_drop = drop;
		w.rule_port = port;
		w.rule_dst_low = lo;
		w.rule_dst_high = hi;
		return w;
	endfunction

	// Random command word. Once the table is full its ranges no longer change, so
	// admits aim inside the stored ranges and adds mostly repeat a stored or the
	// local range; the rest is unconstrained noise that mostly ends in an ask or a
	// refused insert.
	function automatic in_word_t random_word();
		in_word_t w;
		int pick;
		int k;
		w.cmd = CMD_HELLO_REPLY;
		w.src_addr = ADDR_BITS'($urandom);
		w.dst_addr = ADDR_BITS'($urandom);
		w.rule_drop = 1'($urandom);
		w.rule_port = PORT_W'($urandom);
		w.rule_dst_low = ADDR_BITS'($urandom);
		w.rule_dst_high = ADDR_BITS'($urandom);
		pick = $urandom_range(0, 99);
		k = $urandom_range(1, tbl_used - 1);
		if (pick < 45) begin
			w.cmd = CMD_ADMIT;
			if ($urandom_range(0, 9) < 8)
				w.src_addr = ADDR_BITS'($urandom_range(0, reg_max_src));
			if ($urandom_range(0, 9) < 7 && tbl_low[k] <= tbl_high[k])
				w.dst_addr = ADDR_BITS'($urandom_range(tbl_low[k], tbl_high[k]));
		end else if (pick < 75) begin
			w.cmd = CMD_ADD;
			case ($urandom_range(0, 9))
				0, 1: begin
					w.rule_dst_low = reg_local_low;
					w.rule_dst_high = reg_local_high;
				end
				2, 3: begin
				end
				default: begin
					w.rule_dst_low = tbl_low[k];
					w.rule_dst_high = tbl_high[k];
				end
			endcase
		end else if (pick < 88) begin
			w.cmd = CMD_RELAY;
		end
		return w;
	endfunction

	function automatic logic [NB_W-1:0] random_nb();
		int v;
		v = $urandom_range(0, 9);
		if (v == 9)
			return NB_NONE;
		if (v == 8)
			return {1'b1, {(NB_W-1){1'b0}}};
		return NB_W'(v);
	endfunction

	// Word driver: offers the backlog in bursts, with gaps between them when sender_gaps
	// is set, and records a prediction at the edge where each word is taken.
	always @(posedge clk or negedge arst_n) begin
		in_word_t nxt_word;
		logic nxt_valid;
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word <= '0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			nxt_valid = in_valid;
			nxt_word = in_word;
			if (in_valid && cmd_bus.ready) begin
				owed_results.insert(owed_results.size(), table_predict(in_word));
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					nxt_word = cmd_backlog.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left = sender_gaps ? $urandom_range(1, 12) : 0;
					end
				end
			end
			// Valid is written once per edge, so a word that follows straight on
			// keeps valid high without a lower-then-raise in the same step.
			in_valid <= nxt_valid;
			in_word <= nxt_word;
		end
	end

	// Result receiver: a long hold-off on request, otherwise the phase's stall style.
	always @(posedge clk or negedge arst_n) begin
		int hold_cnt;
		int holds_served;
		logic [15:0] stall_pat;
		logic [3:0] pat_step;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt = 0;
			holds_served = 0;
			stall_pat = 16'hA5A5;
			pat_step = '0;
		end else if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_cnt = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			case (stall_mode)
				STALL_NONE: out_ready <= 1'b1;
				STALL_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
				default: begin
					out_ready <= stall_pat[0];
					stall_pat = (pat_step == 4'hF) ? (16'($urandom) | 16'h0101)
						: {stall_pat[0], stall_pat[15:1]};
					pat_step = pat_step + 1'b1;
				end
			endcase
		end
	end

	// Result monitor: every word taken must match the oldest owed result, field by field.
	always @(posedge clk) begin
		out_word_t want;
		out_word_t got;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = res_bus.data;
			if (owed_results.size() == 0) begin
				if (fault_count < REPORT_MAX)
					$display("unexpected result: %s", result_text(got));
				fault_count++;
			end else begin
				want = owed_results.pop_front();
				if (got.ask !== want.ask || got.ask_src !== want.ask_src ||
						got.ask_dst !== want.ask_dst || got.relay_to !== want.relay_to ||
						got.hits !== want.hits || got.inserted !== want.inserted ||
						got.table_full !== want.table_full ||
						got.rules_in_use !== want.rules_in_use) begin
					if (fault_count < REPORT_MAX) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected %s", result_text(want));
						$display("  actual   %s", result_text(got));
					end
					fault_count++;
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// One register write on the configuration channel. Only called while idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!reg_bus.ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LOCAL_LOW: reg_local_low = value;
			CFG_LOCAL_HIGH: reg_local_high = value;
			CFG_NEIGHBOUR_A: reg_nb_a = value[NB_W-1:0];
			CFG_NEIGHBOUR_B: reg_nb_b = value[NB_W-1:0];
			CFG_MAX_SRC: reg_max_src = value;
			default: begin
			end
		endcase
	endtask

	// Writes all five registers. The neighbour registers only keep their low bits,
	// so the bits above them carry random filler.
	task automatic set_regs(input logic [ADDR_BITS-1:0] lo, input logic [ADDR_BITS-1:0] hi,
			input logic [NB_W-1:0] nba, input logic [NB_W-1:0] nbb,
			input logic [ADDR_BITS-1:0] mx);
		logic [CFG_DATA_W-1:0] pad;
		write_reg(CFG_LOCAL_LOW, lo);
		write_reg(CFG_LOCAL_HIGH, hi);
		pad = CFG_DATA_W'($urandom);
		write_reg(CFG_NEIGHBOUR_A, {pad[CFG_DATA_W-1:NB_W], nba});
		pad = CFG_DATA_W'($urandom);
		write_reg(CFG_NEIGHBOUR_B, {pad[CFG_DATA_W-1:NB_W], nbb});
		write_reg(CFG_MAX_SRC, mx);
	endtask

	// Appends one command word to the end of the backlog.
	task automatic queue_word(input in_word_t w);
		cmd_backlog.insert(cmd_backlog.size(), w);
	endtask

	// Holds the sender back until every owed result has come home, then lets the
	// sequencer settle before anything touches the registers.
	task automatic drain();
		do
			@(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || owed_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_random(input int count);
		@(negedge clk);
		repeat (count) queue_word(random_word());
	endtask

	initial begin
		reg_local_low = '0;
		reg_local_high = '0;
		reg_nb_a = NB_NONE;
		reg_nb_b = NB_NONE;
		reg_max_src = MAX_SRC_RESET;
		tbl_used = 1;
		tbl_hits[0] = '0;
		sender_gaps = 1'b0;
		stall_mode = STALL_NONE;
		hold_requests = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words against the reset settings: local rule covers only
		// destination 0, no neighbours, sources up to 1000.
		@(negedge clk);
		queue_word(word_of(CMD_ADMIT, 0, 0, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADMIT, 1000, 0, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADMIT, 1001, 0, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADMIT, 1023, 1023, 1, 7, 1023, 1023));
		queue_word(word_of(CMD_RELAY, 0, 0, 0, 0, 0, 0));
		queue_word(word_of(CMD_HELLO_REPLY, 1023, 1023, 1, 7, 1023, 1023));
		// Forward with no neighbour, then a drop add equal to the local range.
		queue_word(word_of(CMD_ADD, 0, 0, 0, 7, 0, 1023));
		queue_word(word_of(CMD_ADD, 0, 0, 1, 0, 0, 0));
		// An empty range is stored as given and never matches a packet.
		queue_word(word_of(CMD_ADD, 0, 0, 0, 3, 1023, 0));
		queue_word(word_of(CMD_ADMIT, 0, 1023, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADD, 0, 0, 1, 7, 0, 1023));
		drain();

		// Both neighbours on the same switch, widest source bound.
		set_regs(1023, 1023, 5, 5, 1023);
		@(negedge clk);
		queue_word(word_of(CMD_ADD, 0, 0, 0, 5, 100, 200));
		queue_word(word_of(CMD_ADD, 0, 0, 0, 6, 1023, 1023));
		queue_word(word_of(CMD_ADMIT, 1023, 1023, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADMIT, 1023, 150, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADD, 0, 0, 1, 5, 300, 400));
		drain();

		// Empty local range, distinct neighbours, zero source bound.
		set_regs(1023, 0, 1, 2, 0);
		@(negedge clk);
		queue_word(word_of(CMD_ADD, 0, 0, 0, 2, 500, 600));
		queue_word(word_of(CMD_ADD, 0, 0, 0, 1, 1023, 0));
		queue_word(word_of(CMD_ADMIT, 0, 1023, 0, 0, 0, 0));
		queue_word(word_of(CMD_ADMIT, 1, 500, 0, 0, 0, 0));
		queue_word(word_of(CMD_HELLO_REPLY, 0, 0, 0, 0, 0, 0));
		drain();

		// Fill the table with overlapping fresh ranges; the last adds are refused.
		// The overlap lets later admits hit many rules at once.
		set_regs(0, 1023, 0, 7, 1023);
		sender_gaps = 1'b1;
		stall_mode = STALL_RANDOM;
		@(negedge clk);
		for (int k = 0; k < 20; k++)
			queue_word(word_of(CMD_ADD, ADDR_BITS'($urandom), ADDR_BITS'($urandom),
				1'($urandom), PORT_W'($urandom), ADDR_BITS'(700 + k), ADDR_BITS'(710 + k)));
		drain();

		run_random(65);
		drain();

		// No idling on the sender while the receiver holds off for a long stretch:
		// the block holds one result, finishes one more word and then has to stall its input.
		set_regs(512, 512, NB_NONE, 3, 0);
		sender_gaps = 1'b0;
		stall_mode = STALL_NONE;
		run_random(65);
		hold_requests++;
		drain();

		set_regs(ADDR_BITS'($urandom), ADDR_BITS'($urandom), random_nb(), random_nb(),
			ADDR_BITS'($urandom));
		sender_gaps = 1'b1;
		stall_mode = STALL_PATTERN;
		run_random(65);
		drain();

		set_regs(1023, 0, 4, 4, 1000);
		sender_gaps = 1'b0;
		stall_mode = STALL_NONE;
		run_random(65);
		drain();

		set_regs(ADDR_BITS'($urandom), ADDR_BITS'($urandom), random_nb(), random_nb(),
			ADDR_BITS'($urandom));
		stall_mode = STALL_PATTERN;
		run_random(65);
		drain();

		// Most negative neighbour code on port b: it must never select a relay.
		set_regs(ADDR_BITS'($urandom_range(0, 700)), ADDR_BITS'($urandom_range(700, 1023)),
			7, {1'b1, {(NB_W-1){1'b0}}}, 1023);
		sender_gaps = 1'b1;
		stall_mode = STALL_RANDOM;
		run_random(65);
		drain();

		// Every word is answered by now; a short wait catches any stray result.
		repeat (40) @(posedge clk);
		if (fault_count == 0 && owed_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
